// ===== hdl/three_phase_cosine_trajectory_assert.svh =====
// assertion macros shared by the trajectory controller and datapath
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef THREE_PHASE_COSINE_TRAJECTORY_ASSERT_SVH
`define THREE_PHASE_COSINE_TRAJECTORY_ASSERT_SVH

// consequent checked in the same cycle
`define TPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpct: assertion failed");

// consequent checked in the next cycle
`define TPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpct: assertion failed");

`endif

// ===== hdl/tpct_pkg.sv =====
// shared types, constants and the raised cosine table for the trajectory block
// no dependencies
package tpct_pkg;

  localparam int PosBits     = 32;
  localparam int TableDepth  = 1024;
  localparam int IdxBits     = $clog2(TableDepth);
  localparam int HalfDepth   = TableDepth / 2;
  localparam int BlendBits   = 17;
  localparam int PhaseBits   = 16;
  localparam int TickBits    = 18;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;
  localparam int CntBits     = $clog2(IdxBits);
  localparam int ProdBits    = PosBits + 1 + BlendBits + 1;
  localparam int RoundHalf   = 32768;

  localparam longint Q30One   = 64'sd1073741824;
  localparam longint PiQ30    = 64'sd3373259426;
  localparam longint BlendOne = 64'sd65536;

  // horner step denominators, k * 2^30
  localparam longint HornerDen0 = 182 * Q30One;
  localparam longint HornerDen1 = 132 * Q30One;
  localparam longint HornerDen2 = 90 * Q30One;
  localparam longint HornerDen3 = 56 * Q30One;
  localparam longint HornerDen4 = 30 * Q30One;
  localparam longint HornerDen5 = 12 * Q30One;
  localparam longint HornerDen6 = 2 * Q30One;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_RETRACT_TICKS  = 3'd0,
    REG_WAIT_TICKS     = 3'd1,
    REG_EXTEND_TICKS   = 3'd2,
    REG_RETRACT_TARGET = 3'd3,
    REG_RECOVER_TARGET = 3'd4,
    REG_HOLDS_BEGIN    = 3'd5,
    REG_AXIS_ENABLED   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                       start_req;
    logic signed [PosBits-1:0]  fb_pos;
  } in_t;

  typedef struct packed {
    logic signed [PosBits-1:0]  cmd_pos;
    logic                       drive_valid;
    logic        [TickBits-1:0] ticks_left;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic div_step;
    logic rom_rd;
    logic mul;
    logic sum;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blend;
    logic out_free;
  } status_t;

  typedef logic [BlendBits-1:0] blend_tab_t [TableDepth];

  // (1 - cos(pi*j/D)) / 2 in q0.16 via a truncated horner series, j <= D/2
  function automatic logic [BlendBits-1:0] half_blend(longint j);
    longint a;
    longint x2;
    longint t;
    longint q;
    a  = (PiQ30 * j + longint'(HalfDepth)) >>> IdxBits;
    x2 = (a * a) >>> 30;
    t  = Q30One;
    t  = Q30One - (x2 * t) / HornerDen0;
    t  = Q30One - (x2 * t) / HornerDen1;
    t  = Q30One - (x2 * t) / HornerDen2;
    t  = Q30One - (x2 * t) / HornerDen3;
    t  = Q30One - (x2 * t) / HornerDen4;
    t  = Q30One - (x2 * t) / HornerDen5;
    t  = Q30One - (x2 * t) / HornerDen6;
    q = Q30One - t;
    if (q < 0) begin
      q = 0;
    end
    return BlendBits'((q + 16384) >>> 15);
  endfunction

  function automatic blend_tab_t build_blend_table();
    blend_tab_t tab;
    for (int i = 0; i < TableDepth; i++) begin
      if (i <= HalfDepth) begin
        tab[i] = half_blend(longint'(i));
      end else begin
        tab[i] = BlendBits'(BlendOne - longint'(half_blend(longint'(TableDepth - i))));
      end
    end
    return tab;
  endfunction

  localparam blend_tab_t BlendTable = build_blend_table();

endpackage

// ===== hdl/tpct_ctrl.sv =====
// sequencer for one tick: phase select, in blend phases index divide, table read and blend, then output
// depends on tpct_pkg and three_phase_cosine_trajectory_assert.svh
`include "three_phase_cosine_trajectory_assert.svh"

module tpct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output tpct_pkg::cmd_t    cmd_o,
  input  tpct_pkg::status_t status_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CALC = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ROM  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [tpct_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic last_step;

  assign in_stall_o = (state_q != S_IDLE);
  assign last_step  = (cnt_q == tpct_pkg::CntBits'(tpct_pkg::IdxBits - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        cnt_d      = '0;
        // hold phases need no table value
        state_d    = status_i.blend ? S_DIV : S_SUM;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = S_ROM;
        end
      end
      S_ROM: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `TPCT_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd_o))
  `TPCT_ASSERT_NEXT(a_accept_to_calc, in_valid_i && !in_stall_o, state_q == S_CALC)
  `TPCT_ASSERT_NOW(a_load_when_free, cmd_o.out_load, status_i.out_free)
  `TPCT_ASSERT_NOW(a_div_length, state_q == S_ROM,
                   $past(cnt_q) == tpct_pkg::CntBits'(tpct_pkg::IdxBits - 1))

endmodule

// ===== hdl/tpct_datapath.sv =====
// config registers, tick state, index divider, blend table, blend arithmetic, output register
// depends on tpct_pkg and three_phase_cosine_trajectory_assert.svh
`include "three_phase_cosine_trajectory_assert.svh"

module tpct_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tpct_pkg::in_t                       in_i,
  input  logic                                cfg_valid_i,
  input  logic [tpct_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [tpct_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  tpct_pkg::cmd_t                      cmd_i,
  output tpct_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tpct_pkg::out_t                      out_o
);

  localparam int PB = tpct_pkg::PosBits;
  localparam int TB = tpct_pkg::TickBits;
  localparam int HB = tpct_pkg::PhaseBits;

  // configuration
  logic [HB-1:0]        retract_ticks_q, wait_ticks_q, extend_ticks_q;
  logic signed [PB-1:0] retract_target_q, recover_target_q;
  logic                 holds_begin_q, axis_en_q;

  // tick state
  logic [TB-1:0]        tick_q, c_q;
  logic signed [PB-1:0] begin_q;

  // working registers
  logic                 blend_ph_q;
  logic signed [PB-1:0] from_q, hold_q, pos_q;
  logic signed [PB:0]   diff_q;
  logic [TB-1:0]        left_q;
  logic [HB-1:0]        rem_q, den_q;
  logic [tpct_pkg::IdxBits-1:0]   quot_q;
  logic [tpct_pkg::BlendBits-1:0] blend_q;
  logic signed [tpct_pkg::ProdBits-1:0] prod_q;

  tpct_pkg::out_t out_q;
  logic           out_valid_q;

  // phase decode
  logic [TB-1:0]        r_end, w_end, total;
  logic                 in_retract, in_wait, in_extend;
  logic signed [PB-1:0] retract_pt, blend_from, blend_to;
  logic [HB-1:0]        num, den;
  logic [HB:0]          rem_sh;
  logic                 q_bit;
  logic signed [tpct_pkg::ProdBits-1:0] rnd;

  assign r_end      = TB'(retract_ticks_q);
  assign w_end      = r_end + TB'(wait_ticks_q);
  assign total      = w_end + TB'(extend_ticks_q);
  assign in_retract = (c_q < r_end);
  assign in_wait    = (c_q < w_end);
  assign in_extend  = (c_q < total);
  assign retract_pt = holds_begin_q ? begin_q : retract_target_q;

  assign status_o.blend    = in_retract || (!in_wait && in_extend);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (in_retract) begin
      blend_from = begin_q;
      blend_to   = retract_pt;
      num        = HB'(c_q);
      den        = retract_ticks_q;
    end else begin
      blend_from = retract_pt;
      blend_to   = recover_target_q;
      num        = HB'(c_q - w_end);
      den        = extend_ticks_q;
    end
  end

  // restoring divide of num * depth by den, one quotient bit a cycle
  assign rem_sh = {rem_q, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, den_q});

  assign rnd = prod_q + tpct_pkg::ProdBits'(tpct_pkg::RoundHalf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retract_ticks_q  <= HB'(3000);
      wait_ticks_q     <= HB'(1000);
      extend_ticks_q   <= HB'(3000);
      retract_target_q <= '0;
      recover_target_q <= '0;
      holds_begin_q    <= 1'b0;
      axis_en_q        <= 1'b1;
    end else if (cfg_valid_i) begin
      case (tpct_pkg::cfg_reg_e'(cfg_index_i))
        tpct_pkg::REG_RETRACT_TICKS:  retract_ticks_q  <= cfg_data_i[HB-1:0];
        tpct_pkg::REG_WAIT_TICKS:     wait_ticks_q     <= cfg_data_i[HB-1:0];
        tpct_pkg::REG_EXTEND_TICKS:   extend_ticks_q   <= cfg_data_i[HB-1:0];
        tpct_pkg::REG_RETRACT_TARGET: retract_target_q <= cfg_data_i[PB-1:0];
        tpct_pkg::REG_RECOVER_TARGET: recover_target_q <= cfg_data_i[PB-1:0];
        tpct_pkg::REG_HOLDS_BEGIN:    holds_begin_q    <= cfg_data_i[0];
        tpct_pkg::REG_AXIS_ENABLED:   axis_en_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      begin_q <= '0;
    end else if (cmd_i.load) begin
      if (in_i.start_req) begin
        begin_q <= in_i.fb_pos;
        tick_q  <= TB'(1);
      end else if (tick_q != '1) begin
        tick_q <= tick_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q <= in_i.start_req ? '0 : tick_q;
    end
    if (cmd_i.calc) begin
      blend_ph_q <= status_o.blend;
      from_q     <= blend_from;
      diff_q     <= {blend_to[PB-1], blend_to} - {blend_from[PB-1], blend_from};
      hold_q     <= in_wait ? retract_pt : recover_target_q;
      left_q     <= in_extend ? (total - c_q) : '0;
      rem_q      <= num;
      den_q      <= den;
    end
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? HB'(rem_sh - {1'b0, den_q}) : HB'(rem_sh);
      quot_q <= {quot_q[tpct_pkg::IdxBits-2:0], q_bit};
    end
    if (cmd_i.rom_rd) begin
      blend_q <= tpct_pkg::BlendTable[quot_q];
    end
    if (cmd_i.mul) begin
      prod_q <= diff_q * $signed({1'b0, blend_q});
    end
    if (cmd_i.sum) begin
      pos_q <= blend_ph_q ? (from_q + rnd[16 +: PB]) : hold_q;
    end
    if (cmd_i.out_load) begin
      out_q.cmd_pos     <= axis_en_q ? pos_q : '0;
      out_q.drive_valid <= axis_en_q;
      out_q.ticks_left  <= left_q;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TPCT_ASSERT_NEXT(a_div_rem_bound, cmd_i.div_step, rem_q < den_q)
  `TPCT_ASSERT_NEXT(a_start_restarts, cmd_i.load && in_i.start_req,
                    tick_q == TB'(1) && c_q == '0)
  `TPCT_ASSERT_NOW(a_disabled_zero, out_valid_q && !out_q.drive_valid,
                   out_q.cmd_pos == '0)

endmodule

// ===== hdl/three_phase_cosine_trajectory.sv =====
// Per-tick position command generator for one axis with raised cosine blends.
// Input channel: one beat per control tick (start_req, fb_pos), valid/stall.
// Output channel: one beat per input beat (cmd_pos, drive_valid, ticks_left),
//   valid/stall, from an output register.
// Config channel: valid/ready write of a register index and data; ready is always
//   high; write only while no tick is in flight.
// Sequence: a tick in a blend phase goes through phase select, the table index divide
//   (one quotient bit a cycle), table read, multiply, sum and output load; a tick in a
//   hold phase skips the divide, table read and multiply. Only one tick is in work at
//   a time: a new tick is taken only once the last has gone to the output register.
// Stall: a finished beat waits in the output register; the next tick is taken
//   and worked meanwhile, and waits at its last step until the register frees.
// Reset: configuration takes its defaults (3000/1000/3000 ticks, targets zero,
//   axis enabled), tick count and begin position clear, no output beat pending.
//   The blend table is a constant and needs no fill.
// depends on tpct_pkg, tpct_ctrl, tpct_datapath

module three_phase_cosine_trajectory (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tpct_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tpct_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tpct_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [tpct_pkg::CfgDataBits-1:0]     cfg_data_i
);

  tpct_pkg::cmd_t    cmd;
  tpct_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tpct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  tpct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_data_o)
  );

endmodule
